>>> rtl/core/arq_sender_window_assert.svh
// Assertion macros for the ARQ sender window RTL
`ifndef ARQ_SENDER_WINDOW_ASSERT_SVH
`define ARQ_SENDER_WINDOW_ASSERT_SVH
`ifndef SYNTHESIS
// property checked on every rising clock edge, switched off while in reset
`define ARQSW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication checked on every rising clock edge, switched off while in reset
`define ARQSW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ARQSW_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARQSW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/arqsw_pkg.sv
// Shared constants, codes and types of the ARQ sender window
package arqsw_pkg;

  localparam int DEPTH  = 8;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SEQ_W  = 16;
  localparam int TIME_W = 32;
  localparam int CMD_W  = 2;
  localparam int KIND_W = 3;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = TIME_W'(1000);
  localparam logic [CNT_W-1:0]  CNT_FULL    = CNT_W'(DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SENT        = 3'd0,
    KIND_RESENT      = 3'd1,
    KIND_REFUSED     = 3'd2,
    KIND_ACK_OK      = 3'd3,
    KIND_ACK_IGNORED = 3'd4
  } kind_t;

  // result of the shared age / match unit
  typedef struct packed {
    logic match;
    logic stale;
  } age_res_t;

endpackage

>>> rtl/core/arqsw_ifs.sv
// Channel interfaces: command input, result output, configuration write
interface arqsw_in_if;
  logic                       valid;
  logic                       ready;
  logic [arqsw_pkg::CMD_W-1:0] cmd;
  logic [arqsw_pkg::SEQ_W-1:0] seq_number;

  modport source (output valid, output cmd, output seq_number, input ready);
  modport sink   (input valid, input cmd, input seq_number, output ready);
endinterface

interface arqsw_out_if;
  logic                        valid;
  logic                        ready;
  logic [arqsw_pkg::KIND_W-1:0] kind;
  logic [arqsw_pkg::SEQ_W-1:0]  packet_seq;
  logic                        last;

  modport source (output valid, output kind, output packet_seq, output last, input ready);
  modport sink   (input valid, input kind, input packet_seq, input last, output ready);
endinterface

interface arqsw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [arqsw_pkg::TIME_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/arqsw_age_unit.sv
// Shared compare unit: sequence match and wrapped age against the timeout
module arqsw_age_unit (
  input  logic [arqsw_pkg::TIME_W-1:0] tick_now,
  input  logic [arqsw_pkg::TIME_W-1:0] send_time,
  input  logic [arqsw_pkg::TIME_W-1:0] timeout,
  input  logic [arqsw_pkg::SEQ_W-1:0]  entry_seq,
  input  logic [arqsw_pkg::SEQ_W-1:0]  key_seq,
  output arqsw_pkg::age_res_t          res
);
  import arqsw_pkg::*;

  logic [TIME_W-1:0] waited;

  // modulo 2^32 difference
  assign waited    = tick_now - send_time;
  assign res.stale = (waited > timeout);
  assign res.match = (entry_seq == key_seq);

endmodule

>>> rtl/core/arq_sender_window.sv
// Go-back-N ARQ sender window: top level with sequencer and entry store.
// A send is answered from its own state; an ack or a tick first walks the window.
// Throughput: one item at a time; entries are walked one per cycle through one
// shared age/match unit, also when an item resends a full window.
// Results wait in an output register; a stalled sink holds the walk.
// Reset: synchronous, active low; clears count, tick counter, timeout to 1000.
module arq_sender_window (
  input  logic        clk,
  input  logic        rst_n,
  arqsw_in_if.sink    in_ch,
  arqsw_out_if.source out_ch,
  arqsw_cfg_if.sink   cfg_ch
);
  import arqsw_pkg::*;

  `include "arq_sender_window_assert.svh"

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SEND      = 6'b000010,
    ST_ACK_SCAN  = 6'b000100,
    ST_SHIFT     = 6'b001000,
    ST_TICK_SCAN = 6'b010000,
    ST_RESEND    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [SEQ_W-1:0]  seq_mem_r  [DEPTH];
  logic [TIME_W-1:0] time_mem_r [DEPTH];

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [TIME_W-1:0] tick_r, tick_nxt;
  logic [TIME_W-1:0] timeout_r;
  logic [SEQ_W-1:0]  key_r, key_nxt;

  logic              out_vld_r, out_vld_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [SEQ_W-1:0]  out_seq_r, out_seq_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_load;
  logic              slot_free;

  logic              in_acc;
  cmd_t              in_cmd;
  logic [CNT_W-1:0]  idx_inc;
  logic              idx_in_win;
  logic [CNT_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  rd_addr;
  logic [SEQ_W-1:0]  rd_seq_r;
  logic [TIME_W-1:0] rd_time_r;
  age_res_t          age;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [SEQ_W-1:0]  wr_seq;
  logic [TIME_W-1:0] wr_time;

  logic              ack_done;
  logic              tick_acc;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_cmd       = cmd_t'(in_ch.cmd);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_vld_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.packet_seq = out_seq_r;
  assign out_ch.last       = out_last_r;
  assign slot_free         = !out_vld_r || out_ch.ready;

  assign idx_inc    = idx_r + 1'b1;
  assign idx_in_win = (idx_r < count_r);
  // fetch for the next cycle; the shift step reads the entry above the one it writes
  assign rd_idx     = (state_nxt == ST_SHIFT) ? idx_nxt + 1'b1 : idx_nxt;
  assign rd_addr    = rd_idx[IDX_W-1:0];

  arqsw_age_unit u_age (
    .tick_now  (tick_r),
    .send_time (rd_time_r),
    .timeout   (timeout_r),
    .entry_seq (rd_seq_r),
    .key_seq   (key_r),
    .res       (age)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    tick_nxt     = tick_r;
    key_nxt      = key_r;
    out_load     = 1'b0;
    out_kind_nxt = out_kind_r;
    out_seq_nxt  = out_seq_r;
    out_last_nxt = out_last_r;
    wr_en        = 1'b0;
    wr_addr      = idx_r[IDX_W-1:0];
    wr_seq       = rd_seq_r;
    wr_time      = rd_time_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt = in_ch.seq_number;
          idx_nxt = '0;
          unique case (in_cmd)
            CMD_SEND: state_nxt = ST_SEND;
            CMD_ACK:  state_nxt = ST_ACK_SCAN;
            CMD_TICK: begin
              tick_nxt  = tick_r + 1'b1;
              state_nxt = ST_TICK_SCAN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SEND: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_seq_nxt  = key_r;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
          if (count_r == CNT_FULL) begin
            out_kind_nxt = KIND_REFUSED;
          end else begin
            out_kind_nxt = KIND_SENT;
            wr_en        = 1'b1;
            wr_addr      = count_r[IDX_W-1:0];
            wr_seq       = key_r;
            wr_time      = tick_r;
            count_nxt    = count_r + 1'b1;
          end
        end
      end

      ST_ACK_SCAN: begin
        if (idx_in_win) begin
          if (age.match) begin
            if (age.stale) begin
              idx_nxt   = '0;
              state_nxt = ST_RESEND;
            end else begin
              state_nxt = ST_SHIFT;
            end
          end else begin
            idx_nxt = idx_inc;
          end
        end else if (slot_free) begin
          out_load     = 1'b1;
          out_kind_nxt = KIND_ACK_IGNORED;
          out_seq_nxt  = key_r;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      ST_SHIFT: begin
        if (idx_inc < count_r) begin
          // close the gap left by the acked entry
          wr_en   = 1'b1;
          idx_nxt = idx_inc;
        end else if (slot_free) begin
          count_nxt    = count_r - 1'b1;
          out_load     = 1'b1;
          out_kind_nxt = KIND_ACK_OK;
          out_seq_nxt  = key_r;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      ST_TICK_SCAN: begin
        if (!idx_in_win) begin
          state_nxt = ST_IDLE;
        end else if (age.stale) begin
          idx_nxt   = '0;
          state_nxt = ST_RESEND;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      ST_RESEND: begin
        if (slot_free) begin
          wr_en        = 1'b1;
          wr_time      = tick_r;
          out_load     = 1'b1;
          out_kind_nxt = KIND_RESENT;
          out_seq_nxt  = rd_seq_r;
          out_last_nxt = (idx_inc == count_r);
          idx_nxt      = idx_inc;
          if (idx_inc == count_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_vld_nxt = out_load ? 1'b1 : (out_vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      idx_r     <= '0;
      tick_r    <= '0;
      timeout_r <= TIMEOUT_RST;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      tick_r    <= tick_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        timeout_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    out_kind_r <= out_kind_nxt;
    out_seq_r  <= out_seq_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seq_mem_r[wr_addr]  <= wr_seq;
      time_mem_r[wr_addr] <= wr_time;
    end
    rd_seq_r  <= seq_mem_r[rd_addr];
    rd_time_r <= time_mem_r[rd_addr];
  end

  assign ack_done = out_load && (out_kind_nxt == KIND_ACK_OK);
  assign tick_acc = in_acc && (in_cmd == CMD_TICK);

  `ARQSW_ASSERT(a_count_range, clk, rst_n, count_r <= CNT_FULL, "window count beyond depth")
  `ARQSW_ASSERT_IMPL(a_resend_cnt, clk, rst_n, state_r == ST_RESEND, count_r != '0, "empty resend")
  `ARQSW_ASSERT_IMPL(a_ack_drop, clk, rst_n, ack_done, count_nxt == count_r - 1'b1, "ack kept")
  `ARQSW_ASSERT_IMPL(a_tick_only_on_cmd, clk, rst_n, !tick_acc, ##1 $stable(tick_r), "stray tick")
  `ARQSW_ASSERT_IMPL(a_load_slot_free, clk, rst_n, out_load, slot_free, "result overwritten")

endmodule

>>> tb/sv/arq_sender_window_tb.sv
// Self-checking testbench for the go-back-N ARQ sender window
`timescale 1ns / 100ps

module arq_sender_window_tb;
  import arqsw_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 2 * DEPTH + 4;
  localparam int IDLE_LIMIT     = 2000;
  localparam int PHASES         = 7;
  localparam int ITEMS_PER_PHASE = 47;
  localparam int REPORT_MAX     = 10;

  typedef struct {
    kind_t             kind;
    logic [SEQ_W-1:0]  packet_seq;
    logic              last;
  } window_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // Predicts the window and holds the results still to come
  class window_scoreboard;
    logic [SEQ_W-1:0]  win_seq  [DEPTH];
    logic [TIME_W-1:0] win_time [DEPTH];
    int unsigned       win_count;
    logic [TIME_W-1:0] tick_now;
    logic [TIME_W-1:0] ack_timeout;
    window_result_t    pending [$];
    int unsigned       mismatches;

    function new();
      win_count   = 0;
      tick_now    = '0;
      ack_timeout = TIMEOUT_RST;
      mismatches  = 0;
    endfunction

    function void set_timeout(logic [TIME_W-1:0] value);
      ack_timeout = value;
    endfunction

    function void push_result(kind_t kind, logic [SEQ_W-1:0] packet_seq, logic last);
      window_result_t r;
      r.kind       = kind;
      r.packet_seq = packet_seq;
      r.last       = last;
      pending = {pending, r};
    endfunction

    function void resend_window();
      for (int i = 0; i < win_count; i++) begin
        win_time[i] = tick_now;
        push_result(KIND_RESENT, win_seq[i], (i + 1 == win_count));
      end
    endfunction

    function void note_input(logic [CMD_W-1:0] cmd, logic [SEQ_W-1:0] seq_number);
      int hit;
      bit stale;
      logic [TIME_W-1:0] waited;
      hit   = -1;
      stale = 1'b0;
      case (cmd)
        CMD_SEND: begin
          if (win_count >= DEPTH) begin
            push_result(KIND_REFUSED, seq_number, 1'b1);
          end else begin
            win_seq[win_count]  = seq_number;
            win_time[win_count] = tick_now;
            win_count++;
            push_result(KIND_SENT, seq_number, 1'b1);
          end
        end
        CMD_ACK: begin
          for (int i = 0; i < win_count; i++)
            if (hit < 0 && win_seq[i] == seq_number) hit = i;
          if (hit < 0) begin
            push_result(KIND_ACK_IGNORED, seq_number, 1'b1);
          end else begin
            waited = tick_now - win_time[hit];
            if (waited <= ack_timeout) begin
              for (int j = hit; j + 1 < win_count; j++) begin
                win_seq[j]  = win_seq[j + 1];
                win_time[j] = win_time[j + 1];
              end
              win_count--;
              push_result(KIND_ACK_OK, seq_number, 1'b1);
            end else begin
              resend_window();
            end
          end
        end
        CMD_TICK: begin
          tick_now = tick_now + 1;
          for (int i = 0; i < win_count; i++) begin
            waited = tick_now - win_time[i];
            if (waited > ack_timeout) stale = 1'b1;
          end
          if (stale) resend_window();
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] packet_seq,
                               logic last);
      window_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: kind=%0d seq=%h last=%b", kind, packet_seq, last);
        return;
      end
      want = pending.pop_front();
      if (kind !== want.kind || packet_seq !== want.packet_seq || last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: expected kind=%0d seq=%h last=%b, got kind=%0d seq=%h last=%b",
                   want.kind, want.packet_seq, want.last, kind, packet_seq, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  arqsw_in_if  in_ch ();
  arqsw_out_if out_ch ();
  arqsw_cfg_if cfg_ch ();

  arq_sender_window dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  window_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // one item to the block; returns at the edge where it is taken
  task automatic issue(logic [CMD_W-1:0] cmd, logic [SEQ_W-1:0] seq_number);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.seq_number <= seq_number;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(cmd, seq_number);
  endtask

  // stop sending, let every result drain and the block settle
  task automatic drain_window();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [TIME_W-1:0] value);
    drain_window();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_timeout(value);
    cfg_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  function automatic logic [SEQ_W-1:0] pick_seq();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return SEQ_W'($urandom);
    if (r < 8) return SEQ_W'($urandom_range(0, 7));
    return ($urandom_range(0, 1) == 1) ? {SEQ_W{1'b1}} : '0;
  endfunction

  // mostly sends and acks of outstanding packets, ticks and a little noise
  task automatic random_item(output bit counted);
    int r;
    logic [SEQ_W-1:0] s;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    if (r < 36) begin
      issue(CMD_SEND, pick_seq());
    end else if (r < 68) begin
      if (sb.win_count > 0 && $urandom_range(0, 4) != 0)
        s = sb.win_seq[$urandom_range(0, sb.win_count - 1)];
      else
        s = pick_seq();
      issue(CMD_ACK, s);
    end else if (r < 96) begin
      issue(CMD_TICK, SEQ_W'($urandom));
    end else begin
      counted = 1'b0;
      issue(CMD_UNUSED, SEQ_W'($urandom));
    end
  endtask

  // result side: stall pattern changes every so often
  initial begin
    stall_mode_t mode;
    int span;
    int cyc;
    cyc = 0;
    out_ch.ready <= 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk);
        cyc++;
        case (mode)
          STALL_NONE:  out_ch.ready <= 1'b1;
          STALL_HALF:  out_ch.ready <= 1'($urandom_range(0, 1));
          STALL_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     out_ch.ready <= (cyc % 6 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.kind, out_ch.packet_seq, out_ch.last);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL arq_sender_window");
        $finish;
      end
    end
  end

  initial begin
    logic [TIME_W-1:0] t;
    int done;
    bit counted;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_SEND;
    in_ch.seq_number <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset timeout, extremes, duplicates, full window, unused code
    issue(CMD_SEND, 16'h0000);
    issue(CMD_SEND, 16'hFFFF);
    issue(CMD_SEND, 16'h00FF);
    issue(CMD_SEND, 16'h0000);
    issue(CMD_ACK, 16'hFFFF);       // removed from the middle
    issue(CMD_ACK, 16'h1234);       // no match
    issue(CMD_UNUSED, 16'hAAAA);
    issue(CMD_TICK, 16'h5555);      // nothing stale
    issue(CMD_ACK, 16'h0000);       // oldest duplicate only
    for (int i = 1; i <= DEPTH - 2; i++) issue(CMD_SEND, SEQ_W'(i));
    issue(CMD_SEND, 16'h5555);      // window full
    issue(CMD_TICK, 16'h0000);
    issue(CMD_TICK, 16'hFFFF);

    // lowering the timeout under waiting entries makes the next ack late
    write_timeout('0);
    issue(CMD_ACK, 16'h00FF);
    issue(CMD_TICK, 16'h0000);      // every entry stale, one resend
    issue(CMD_ACK, 16'h0000);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       t = {TIME_W{1'b1}};
        1:       t = '0;
        2:       t = TIME_W'(2);
        3:       t = TIME_W'($urandom);
        4:       t = TIME_W'(1);
        5:       t = TIME_W'($urandom_range(3, 9));
        default: t = TIME_W'(4);
      endcase
      write_timeout(t);
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        random_item(counted);
        if (counted) done++;
      end
    end

    drain_window();
    if (sb.pending.size() != 0)
      $display("%0d expected results never arrived", sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS arq_sender_window");
    end else begin
      $display("FAIL arq_sender_window");
    end
    $finish;
  end

endmodule
